// ===== hdl/rbst_pkg.sv =====
// package for the ray versus box slab test: widths, register codes, saturation helpers
package rbst_pkg;

    localparam int COORD_W      = 32;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = DIFF_W + COORD_W;
    localparam int FRAC_W       = 16;
    localparam int DIST_W       = 31;
    localparam int NUM_AXES     = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int S_TDATA_W    = 224;
    localparam int M_TDATA_W    = 64;
    localparam int MARGIN_SHIFT_DEF = 20;

    // register index codes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOX_MIN_X = 3'd0,
        CFG_BOX_MIN_Y = 3'd1,
        CFG_BOX_MIN_Z = 3'd2,
        CFG_BOX_MAX_X = 3'd3,
        CFG_BOX_MAX_Y = 3'd4,
        CFG_BOX_MAX_Z = 3'd5
    } t_cfg_idx;

    // floor(p / 2^16) saturated to signed 32 bit
    function automatic logic signed [COORD_W-1:0] sat_prod(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-COORD_W-FRAC_W:0] hi;
        logic signed [COORD_W-1:0]      res;
        hi = p[PROD_W-1:COORD_W+FRAC_W-1];
        if ((&hi) || !(|hi)) begin
            res = p[COORD_W+FRAC_W-1:FRAC_W];
        end else if (p[PROD_W-1]) begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return res;
    endfunction

    // 33 bit sum saturated to signed 32 bit
    function automatic logic signed [COORD_W-1:0] sat_sum(input logic signed [COORD_W:0] s);
        logic signed [COORD_W-1:0] res;
        if (s[COORD_W] == s[COORD_W-1]) begin
            res = s[COORD_W-1:0];
        end else if (s[COORD_W]) begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

// ===== hdl/ray_box_slab_test.sv =====
// ray versus axis-aligned box slab test, four register stages with per-stage flow control
// an accepted beat passes through the stage 1, 2, 3 and 4 registers in turn and leaves stage 4 on the master side
// throughput: one ray per cycle while the output is not blocked, set by the four stage pipeline (capture, multiply,
//   slab ordering and margin, interval clipping); a stage loads when empty or when the next moves
// reset: i_rst_n synchronous active low clears all stage valid bits and the six box
//   corner registers to zero; payload registers are not reset
module ray_box_slab_test #(
    parameter int MARGIN_SHIFT = rbst_pkg::MARGIN_SHIFT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_wr_en,
    input  logic [rbst_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rbst_pkg::COORD_W-1:0]       i_cfg_data,
    // ray input
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z, ray_tmax, zero pad
    input  logic [rbst_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // result output
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // t_enter, t_exit, zero pad
    output logic [rbst_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // hit
    output logic                               m_axis_tuser
);
    import rbst_pkg::*;

    // box corners
    logic signed [COORD_W-1:0] r_box_min [NUM_AXES];
    logic signed [COORD_W-1:0] r_box_max [NUM_AXES];

    // stage valid bits and enables
    logic r_v1, r_v2, r_v3, r_v4;
    logic s1_en, s2_en, s3_en, s4_en;

    // stage 1: differences and reciprocals
    logic signed [DIFF_W-1:0]  r_diff_lo [NUM_AXES];
    logic signed [DIFF_W-1:0]  r_diff_hi [NUM_AXES];
    logic signed [COORD_W-1:0] r_inv1    [NUM_AXES];
    logic [DIST_W-1:0]         r_tmax1;
    logic signed [DIFF_W-1:0]  n_diff_lo [NUM_AXES];
    logic signed [DIFF_W-1:0]  n_diff_hi [NUM_AXES];

    // stage 2: raw products
    logic signed [PROD_W-1:0]  r_prod_lo [NUM_AXES];
    logic signed [PROD_W-1:0]  r_prod_hi [NUM_AXES];
    logic [DIST_W-1:0]         r_tmax2;
    logic signed [PROD_W-1:0]  n_prod_lo [NUM_AXES];
    logic signed [PROD_W-1:0]  n_prod_hi [NUM_AXES];

    // stage 3: ordered slab distances, far widened
    logic signed [COORD_W-1:0] r_tn [NUM_AXES];
    logic signed [COORD_W-1:0] r_tf [NUM_AXES];
    logic [DIST_W-1:0]         r_tmax3;
    logic signed [COORD_W-1:0] n_tn [NUM_AXES];
    logic signed [COORD_W-1:0] n_tf [NUM_AXES];

    // stage 4: result register
    logic                      r_hit;
    logic [DIST_W-1:0]         r_t_enter;
    logic [DIST_W-1:0]         r_t_exit;
    logic                      n_hit;
    logic [DIST_W-1:0]         n_t_enter;
    logic [DIST_W-1:0]         n_t_exit;

    // configuration writes, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_box_min[a] <= '0;
                r_box_max[a] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BOX_MIN_X: r_box_min[0] <= i_cfg_data;
                CFG_BOX_MIN_Y: r_box_min[1] <= i_cfg_data;
                CFG_BOX_MIN_Z: r_box_min[2] <= i_cfg_data;
                CFG_BOX_MAX_X: r_box_max[0] <= i_cfg_data;
                CFG_BOX_MAX_Y: r_box_max[1] <= i_cfg_data;
                CFG_BOX_MAX_Z: r_box_max[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // flow control: a stage loads when empty or when the one after it moves
    assign s4_en         = !r_v4 || m_axis_tready;
    assign s3_en         = !r_v3 || s4_en;
    assign s2_en         = !r_v2 || s3_en;
    assign s1_en         = !r_v1 || s2_en;
    assign s_axis_tready = s1_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (s1_en) r_v1 <= s_axis_tvalid;
            if (s2_en) r_v2 <= r_v1;
            if (s3_en) r_v3 <= r_v2;
            if (s4_en) r_v4 <= r_v3;
        end
    end

    // corner minus origin, exact in 33 bits
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            n_diff_lo[a] = {r_box_min[a][COORD_W-1], r_box_min[a]}
                         - {s_axis_tdata[COORD_W*a + COORD_W-1], s_axis_tdata[COORD_W*a +: COORD_W]};
            n_diff_hi[a] = {r_box_max[a][COORD_W-1], r_box_max[a]}
                         - {s_axis_tdata[COORD_W*a + COORD_W-1], s_axis_tdata[COORD_W*a +: COORD_W]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_diff_lo[a] <= n_diff_lo[a];
                r_diff_hi[a] <= n_diff_hi[a];
                r_inv1[a]    <= s_axis_tdata[COORD_W*(NUM_AXES+a) +: COORD_W];
            end
            r_tmax1 <= s_axis_tdata[COORD_W*2*NUM_AXES +: DIST_W];
        end
    end

    // slab products, full precision
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            n_prod_lo[a] = r_diff_lo[a] * r_inv1[a];
            n_prod_hi[a] = r_diff_hi[a] * r_inv1[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_en) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_prod_lo[a] <= n_prod_lo[a];
                r_prod_hi[a] <= n_prod_hi[a];
            end
            r_tmax2 <= r_tmax1;
        end
    end

    // scale and saturate, order near and far, widen far by its shifted copy
    always_comb begin
        logic signed [COORD_W-1:0] ta;
        logic signed [COORD_W-1:0] tb;
        logic signed [COORD_W-1:0] far;
        logic signed [COORD_W-1:0] marg;
        for (int a = 0; a < NUM_AXES; a++) begin
            ta   = sat_prod(r_prod_lo[a]);
            tb   = sat_prod(r_prod_hi[a]);
            if (ta > tb) begin
                n_tn[a] = tb;
                far     = ta;
            end else begin
                n_tn[a] = ta;
                far     = tb;
            end
            marg    = far >>> MARGIN_SHIFT;
            n_tf[a] = sat_sum({far[COORD_W-1], far} + {marg[COORD_W-1], marg});
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_en) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_tn[a] <= n_tn[a];
                r_tf[a] <= n_tf[a];
            end
            r_tmax3 <= r_tmax2;
        end
    end

    // clip [0, tmax] against the three slabs
    always_comb begin
        logic signed [COORD_W-1:0] t0;
        logic signed [COORD_W-1:0] t1;
        t0 = '0;
        t1 = {1'b0, r_tmax3};
        for (int a = 0; a < NUM_AXES; a++) begin
            if (r_tn[a] > t0) t0 = r_tn[a];
            if (r_tf[a] < t1) t1 = r_tf[a];
        end
        n_hit = (t0 <= t1);
        if (n_hit) begin
            n_t_enter = t0[DIST_W-1:0];
            n_t_exit  = t1[DIST_W-1:0];
        end else begin
            n_t_enter = '0;
            n_t_exit  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s4_en) begin
            r_hit     <= n_hit;
            r_t_enter <= n_t_enter;
            r_t_exit  <= n_t_exit;
        end
    end

    assign m_axis_tvalid = r_v4;
    assign m_axis_tuser  = r_hit;
    assign m_axis_tdata  = {{(M_TDATA_W-2*DIST_W){1'b0}}, r_t_exit, r_t_enter};

    // a hit always has a non-empty interval
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> r_t_enter <= r_t_exit)
        else $error("hit with entry beyond exit");

    // a miss carries zero distances
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> r_t_enter == '0 && r_t_exit == '0)
        else $error("miss with nonzero distances");

    // input only stalls when every stage is full and the output is blocked
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_v1 && r_v2 && r_v3 && m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with room in the pipeline");

    // nothing comes out in the first cycle after reset
    assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output beat right after reset");

endmodule
